// ===== design/pansharpen_pixel_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pansharpening pixel unit
// Both macros expect signals named clk and rst in the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef PANSHARPEN_PIXEL_UNIT_ASSERT_SVH
`define PANSHARPEN_PIXEL_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define PANSH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PANSH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pansh_pkg.sv =====
// ----------------------------------------------------------------------------
// pansh_pkg
// Shared types and constants of the pansharpening pixel unit.
// ----------------------------------------------------------------------------
package pansh_pkg;

  // Width of one sample field on the input stream.
  localparam int IN_W      = 16;
  // Number of multispectral bands, one lane each.
  localparam int NUM_BANDS = 4;
  // Width of one sharpened band on the output stream.
  localparam int OUT_W     = 26;

  // Saturation limits of a sharpened band.
  localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sh1FFFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 26'sh2000000;

  // Register map.
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_MODE = 3'd0;

  // Sharpening method.
  typedef enum logic {
    MODE_BROVEY = 1'b0,
    MODE_IHS    = 1'b1
  } mode_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic [OUT_W-1:0] brovey;
    logic [OUT_W-1:0] ihs;
  } lane_res_t;

endpackage

// ===== design/pansh_div.sv =====
// ----------------------------------------------------------------------------
// pansh_div
// Pipelined restoring divider: one quotient bit per stage, each stage a
// compare and subtract of the partial remainder against the divisor.
// ----------------------------------------------------------------------------
module pansh_div #(
  parameter int SUM_W = 18,
  parameter int Q_W   = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] rem_in,
  input  logic [Q_W-1:0]   low_in,
  input  logic [SUM_W-1:0] dvs_in,
  output logic [Q_W-1:0]   quot
);

  // Stage registers: partial remainder, remaining dividend bits with the
  // quotient bits shifted in behind them, and the divisor of that item.
  logic [SUM_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [SUM_W-1:0] dvs_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [SUM_W-1:0] r_src;
    logic [Q_W-1:0]   l_src;
    logic [SUM_W-1:0] d_src;
    logic [SUM_W:0]   trial;
    logic [SUM_W:0]   diff;
    logic             ge;

    // Stage input comes from the previous stage or from the lane.
    if (k == 0) begin : g_first
      assign r_src = rem_in;
      assign l_src = low_in;
      assign d_src = dvs_in;
    end else begin : g_rest
      assign r_src = rem_r[k-1];
      assign l_src = low_r[k-1];
      assign d_src = dvs_r[k-1];
    end

    // Bring down one dividend bit and try to subtract the divisor.
    assign trial = {r_src, l_src[Q_W-1]};
    assign diff  = trial - {1'b0, d_src};
    assign ge    = (trial >= {1'b0, d_src});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        low_r[k] <= {l_src[Q_W-2:0], ge};
        dvs_r[k] <= d_src;
      end
    end
  end

  assign quot = low_r[Q_W-1];

endmodule

// ===== design/pansh_lane.sv =====
// ----------------------------------------------------------------------------
// pansh_lane
// One band of the pixel: product with pan and the ratio by the band sum for
// the Brovey method, and the additive fast-IHS value kept alongside it.
// ----------------------------------------------------------------------------
module pansh_lane import pansh_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] band,
  input  logic [SAMPLE_BITS-1:0] pan,
  input  logic [SAMPLE_BITS+1:0] sum,
  output lane_res_t              res
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SUM_W = S + 2;
  localparam int Q_W   = S + F;
  localparam int IHS_W = S + F + 2;
  localparam int EXT_W = (IHS_W > OUT_W) ? IHS_W : OUT_W;
  localparam int QX_W  = (Q_W > OUT_W) ? Q_W : OUT_W;

  logic [2*S-1:0]          prod;
  logic [S:0]              band_pan;
  logic signed [IHS_W-1:0] ihs_full;
  logic signed [EXT_W-1:0] ihs_ext;
  logic [OUT_W-1:0]        ihs_sat;

  logic [2*S-1:0]          prod_r;
  logic [SUM_W-1:0]        sum_r;
  logic [OUT_W-1:0]        ihs_d [Q_W+1];

  logic [Q_W-1:0]          quot;
  logic [QX_W-1:0]         quot_x;

  // Product of band and pan for the ratio.
  assign prod = (2*S)'(band) * (2*S)'(pan);

  // Fast IHS: (band + pan) scaled minus a quarter of the sum, all scaled.
  assign band_pan = (S+1)'(band) + (S+1)'(pan);
  assign ihs_full = $signed(IHS_W'(band_pan) << F) - $signed(IHS_W'(sum) << (F - 2));
  assign ihs_ext  = EXT_W'(ihs_full);

  always_comb begin
    if (ihs_ext > EXT_W'(OUT_MAX)) begin
      ihs_sat = OUT_MAX;
    end else if (ihs_ext < EXT_W'(OUT_MIN)) begin
      ihs_sat = OUT_MIN;
    end else begin
      ihs_sat = ihs_ext[OUT_W-1:0];
    end
  end

  // Product stage; the IHS value rides along with the divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod;
      sum_r    <= sum;
      ihs_d[0] <= ihs_sat;
      for (int k = 1; k <= Q_W; k++) begin
        ihs_d[k] <= ihs_d[k-1];
      end
    end
  end

  // The quotient is at most pan * 2^F, so the upper product bits already sit
  // below the divisor and form the starting remainder.
  pansh_div #(
    .SUM_W (SUM_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk    (clk),
    .en     (en),
    .rem_in (SUM_W'(prod_r[2*S-1:S])),
    .low_in ({prod_r[S-1:0], {F{1'b0}}}),
    .dvs_in (sum_r),
    .quot   (quot)
  );

  // Saturate the ratio to the output range.
  assign quot_x = QX_W'(quot);

  always_comb begin
    if (quot_x > QX_W'(OUT_MAX)) begin
      res.brovey = OUT_MAX;
    end else begin
      res.brovey = quot_x[OUT_W-1:0];
    end
    res.ihs = ihs_d[Q_W];
  end

endmodule

// ===== design/pansharpen_pixel_unit.sv =====
// Throughput: one pixel per cycle while the skid stage is empty; each lane's divider
// retires one quotient bit per pipeline stage. Reset empties the pipeline and selects
// the Brovey method. A pixel passes the input register, the product stage, the divider
// stages and the output register on its way to m_tvalid.
// ----------------------------------------------------------------------------
// pansharpen_pixel_unit
// Brovey and fast-IHS pansharpening of one pixel per transfer: four band lanes
// run side by side and a merge stage picks the method's result per band.
// ----------------------------------------------------------------------------
module pansharpen_pixel_unit import pansh_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Pixel stream in: red_in, green_in, blue_in, nir_in, pan_in.
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [5*IN_W-1:0]        s_tdata,
  // Result stream out: red_out, green_out, blue_out, nir_out.
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [NUM_BANDS*OUT_W-1:0] m_tdata,
  // zero_sum.
  output logic                     m_tuser
);

  `include "pansharpen_pixel_unit_assert.svh"

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int SUM_W = S + 2;
  localparam int Q_W   = S + F;
  localparam int D_W   = NUM_BANDS * OUT_W;

  mode_t            mode;

  logic             en;
  logic             v_in;
  logic [S-1:0]     in_band [NUM_BANDS];
  logic [S-1:0]     in_pan;
  mode_t            in_mode;
  logic [SUM_W-1:0] sum_c;

  logic [Q_W:0]     v_pipe;
  logic [Q_W:0]     ihs_pipe;
  logic [Q_W:0]     zero_pipe;

  lane_res_t        res [NUM_BANDS];

  logic [D_W-1:0]   merged_data;
  logic             merged_zero;

  logic             out_v;
  logic [D_W-1:0]   out_data;
  logic             out_zero;
  logic             skid_v;
  logic [D_W-1:0]   skid_data;
  logic             skid_zero;
  logic             out_take;

  // Configuration register; only bit 0 of a written word is kept.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BROVEY;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == ADDR_MODE[ADDR_W-1:2]) begin
      mode <= mode_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == ADDR_MODE[ADDR_W-1:2]) begin
      prdata[0] = mode;
    end
  end

  // The pipeline moves whenever the skid stage is empty.
  assign en       = !skid_v;
  assign s_tready = en;

  // Input stage and the valid / method / zero-sum tags of each stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_pipe <= '0;
    end else if (en) begin
      v_in   <= s_tvalid;
      v_pipe <= {v_pipe[Q_W-1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_tvalid) begin
        for (int i = 0; i < NUM_BANDS; i++) begin
          in_band[i] <= s_tdata[i*IN_W +: S];
        end
        in_pan  <= s_tdata[NUM_BANDS*IN_W +: S];
        in_mode <= mode;
      end
      ihs_pipe  <= {ihs_pipe[Q_W-1:0], in_mode == MODE_IHS};
      zero_pipe <= {zero_pipe[Q_W-1:0], sum_c == '0};
    end
  end

  // Band sum, shared by all lanes.
  assign sum_c = SUM_W'(in_band[0]) + SUM_W'(in_band[1]) +
                 SUM_W'(in_band[2]) + SUM_W'(in_band[3]);

  // One lane per band.
  for (genvar i = 0; i < NUM_BANDS; i++) begin : g_lane
    pansh_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .band (in_band[i]),
      .pan  (in_pan),
      .sum  (sum_c),
      .res  (res[i])
    );
  end

  // Merge: pick the method's value per band; in Brovey mode a zero sum forces zeros.
  always_comb begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      if (ihs_pipe[Q_W]) begin
        merged_data[i*OUT_W +: OUT_W] = res[i].ihs;
      end else if (zero_pipe[Q_W]) begin
        merged_data[i*OUT_W +: OUT_W] = '0;
      end else begin
        merged_data[i*OUT_W +: OUT_W] = res[i].brovey;
      end
    end
    merged_zero = !ihs_pipe[Q_W] && zero_pipe[Q_W];
  end

  // Output register with a skid stage behind it.
  assign out_take = out_v && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_take) begin
        skid_v <= 1'b0;
      end
    end else if (v_pipe[Q_W]) begin
      if (!out_v || out_take) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_take) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_take) begin
        out_data <= skid_data;
        out_zero <= skid_zero;
      end
    end else if (v_pipe[Q_W]) begin
      if (!out_v || out_take) begin
        out_data <= merged_data;
        out_zero <= merged_zero;
      end else begin
        skid_data <= merged_data;
        skid_zero <= merged_zero;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;
  assign m_tuser  = out_zero;

  // The skid stage only holds a result while the output register is full.
  `PANSH_ASSERT_IMP(a_skid_needs_out, skid_v, out_v, "skid holds data with empty output")
  // The skid stage fills only from a stalled output transfer.
  `PANSH_ASSERT_IMP(a_skid_fill, $rose(skid_v), $past(out_v && !m_tready), "skid filled without stall")
  // The pipeline holds still while the skid stage is full.
  `PANSH_ASSERT_NXT(a_pipe_frozen, skid_v, $stable(v_pipe), "pipeline moved during stall")
  // A zero-sum result carries all-zero bands.
  `PANSH_ASSERT_IMP(a_zero_bands, out_v && m_tuser, m_tdata == '0, "zero sum with nonzero bands")

endmodule
